FILE: sv/rational_arithmetic_unit_assert.svh
// assertion macros for the rational arithmetic unit checker
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH

// same-cycle implication
`define RAU_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rau check failed");

// next-cycle implication
`define RAU_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rau check failed");

`endif

FILE: sv/rau_pkg.sv
package rau_pkg;

	localparam int OPW = 16;
	localparam int PROD_W = 2 * OPW;
	localparam int RES_W = 2 * OPW + 1;
	localparam int DIV_CNT_W = $clog2(OPW);

	localparam logic [2:0] MODE_ADD = 3'd0;
	localparam logic [2:0] MODE_SUB = 3'd1;
	localparam logic [2:0] MODE_MUL = 3'd2;
	localparam logic [2:0] MODE_DIV = 3'd3;
	localparam logic [2:0] MODE_RED = 3'd4;
	localparam logic [2:0] MODE_CMP = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_GCD_CHECK,
		ST_GCD_WAIT,
		ST_NUM_WAIT,
		ST_DEN_WAIT,
		ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		DIV_GCD,
		DIV_NUM,
		DIV_DEN
	} div_sel_t;

	typedef struct packed {
		logic     load;
		logic     mul1;
		logic     mul2;
		logic     gcd_init;
		logic     gcd_step;
		logic     div_start;
		div_sel_t div_sel;
		logic     store_qn;
		logic     finish;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] mode;
		logic       gx_zero;
		logic       gy_zero;
		logic       div_done;
	} dp_stat_t;

endpackage

FILE: sv/rau_if.sv
interface rau_in_if;
	logic                            valid;
	logic                            ready;
	logic [2:0]                      mode;
	logic signed [rau_pkg::OPW-1:0]  a_num;
	logic signed [rau_pkg::OPW-1:0]  a_den;
	logic signed [rau_pkg::OPW-1:0]  b_num;
	logic signed [rau_pkg::OPW-1:0]  b_den;

	modport source (output valid, mode, a_num, a_den, b_num, b_den, input ready);
	modport sink (input valid, mode, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
	logic                             valid;
	logic                             ready;
	logic signed [rau_pkg::RES_W-1:0] res_num;
	logic signed [rau_pkg::RES_W-1:0] res_den;
	logic                             greater;
	logic                             error;

	modport source (output valid, res_num, res_den, greater, error, input ready);
	modport sink (input valid, res_num, res_den, greater, error, output ready);
endinterface

FILE: sv/rau_div.sv
module rau_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [rau_pkg::OPW-1:0]    dividend,
	input  logic signed [rau_pkg::OPW-1:0]    divisor,
	output logic                              done,
	output logic signed [rau_pkg::OPW:0]      quot,
	output logic signed [rau_pkg::OPW-1:0]    rem
);

	logic                              busy_q;
	logic                              done_q;
	logic [rau_pkg::DIV_CNT_W-1:0]     cnt_q;
	logic [rau_pkg::OPW-1:0]           rem_q;
	logic [rau_pkg::OPW-1:0]           quo_q;
	logic [rau_pkg::OPW-1:0]           dsr_q;
	logic                              neg_q_q;
	logic                              neg_r_q;
	logic [rau_pkg::OPW:0]             trial;
	logic [rau_pkg::OPW+1:0]           diff;
	logic                              take;
	logic [rau_pkg::OPW:0]             quo_ext;

	function automatic logic [rau_pkg::OPW-1:0] mag(input logic signed [rau_pkg::OPW-1:0] v);
		return v[rau_pkg::OPW-1] ? (~v + 1'b1) : v;
	endfunction

	assign trial = {rem_q, quo_q[rau_pkg::OPW-1]};
	assign diff = {1'b0, trial} - {2'b00, dsr_q};
	assign take = !diff[rau_pkg::OPW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= rau_pkg::DIV_CNT_W'(rau_pkg::OPW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= mag(dividend);
			dsr_q <= mag(divisor);
			neg_q_q <= dividend[rau_pkg::OPW-1] ^ divisor[rau_pkg::OPW-1];
			neg_r_q <= dividend[rau_pkg::OPW-1];
		end else if (busy_q) begin
			rem_q <= take ? diff[rau_pkg::OPW-1:0] : trial[rau_pkg::OPW-1:0];
			quo_q <= {quo_q[rau_pkg::OPW-2:0], take};
		end
	end

	assign quo_ext = {1'b0, quo_q};
	assign quot = neg_q_q ? -quo_ext : quo_ext;
	assign rem = neg_r_q ? -rem_q : rem_q;
	assign done = done_q;

endmodule

FILE: sv/rau_datapath.sv
module rau_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [2:0]                        mode,
	input  logic signed [rau_pkg::OPW-1:0]    a_num,
	input  logic signed [rau_pkg::OPW-1:0]    a_den,
	input  logic signed [rau_pkg::OPW-1:0]    b_num,
	input  logic signed [rau_pkg::OPW-1:0]    b_den,
	input  rau_pkg::dp_cmd_t                  cmd,
	output rau_pkg::dp_stat_t                 stat,
	output logic signed [rau_pkg::RES_W-1:0]  res_num,
	output logic signed [rau_pkg::RES_W-1:0]  res_den,
	output logic                              greater,
	output logic                              error
);

	localparam int EXT_P = rau_pkg::RES_W - rau_pkg::PROD_W;
	localparam int EXT_Q = rau_pkg::RES_W - rau_pkg::OPW - 1;

	logic [2:0]                          mode_q;
	logic signed [rau_pkg::OPW-1:0]      an_q, ad_q, bn_q, bd_q;
	logic signed [rau_pkg::OPW-1:0]      gx_q, gy_q;
	logic signed [rau_pkg::PROD_W-1:0]   p1_q, p2_q, p3_q, p4_q;
	logic signed [rau_pkg::OPW:0]        qn_q;
	logic signed [rau_pkg::RES_W-1:0]    num_q, den_q;
	logic                                greater_q, error_q;

	logic signed [rau_pkg::OPW-1:0]      m0_x, m1_x;
	logic signed [rau_pkg::PROD_W-1:0]   m0, m1;
	logic signed [rau_pkg::OPW-1:0]      dv_x, dv_y;
	logic                                dv_done;
	logic signed [rau_pkg::OPW:0]        dv_quot;
	logic signed [rau_pkg::OPW-1:0]      dv_rem;
	logic signed [rau_pkg::RES_W-1:0]    e1, e2, e3, e4, eqn, eqd;
	logic signed [rau_pkg::RES_W-1:0]    num_d, den_d;
	logic                                greater_d, error_d;

	assign m0_x = cmd.mul2 ? ad_q : an_q;
	assign m1_x = cmd.mul2 ? an_q : ad_q;
	assign m0 = m0_x * bd_q;
	assign m1 = m1_x * bn_q;

	always_comb begin
		case (cmd.div_sel)
			rau_pkg::DIV_GCD: begin
				dv_x = gx_q;
				dv_y = gy_q;
			end
			rau_pkg::DIV_NUM: begin
				dv_x = an_q;
				dv_y = gx_q;
			end
			rau_pkg::DIV_DEN: begin
				dv_x = ad_q;
				dv_y = gx_q;
			end
			default: begin
				dv_x = gx_q;
				dv_y = gy_q;
			end
		endcase
	end

	rau_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dv_x),
		.divisor  (dv_y),
		.done     (dv_done),
		.quot     (dv_quot),
		.rem      (dv_rem)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			an_q <= a_num;
			ad_q <= a_den;
			bn_q <= b_num;
			bd_q <= b_den;
		end
		if (cmd.mul1) begin
			p1_q <= m0;
			p2_q <= m1;
		end
		if (cmd.mul2) begin
			p3_q <= m0;
			p4_q <= m1;
		end
		if (cmd.gcd_init) begin
			gx_q <= an_q;
			gy_q <= ad_q;
		end else if (cmd.gcd_step) begin
			gx_q <= gy_q;
			gy_q <= dv_rem;
		end
		if (cmd.store_qn) begin
			qn_q <= dv_quot;
		end
		if (cmd.finish) begin
			num_q <= num_d;
			den_q <= den_d;
			greater_q <= greater_d;
			error_q <= error_d;
		end
	end

	assign e1 = {{EXT_P{p1_q[rau_pkg::PROD_W-1]}}, p1_q};
	assign e2 = {{EXT_P{p2_q[rau_pkg::PROD_W-1]}}, p2_q};
	assign e3 = {{EXT_P{p3_q[rau_pkg::PROD_W-1]}}, p3_q};
	assign e4 = {{EXT_P{p4_q[rau_pkg::PROD_W-1]}}, p4_q};
	assign eqn = {{EXT_Q{qn_q[rau_pkg::OPW]}}, qn_q};
	assign eqd = {{EXT_Q{dv_quot[rau_pkg::OPW]}}, dv_quot};

	always_comb begin
		num_d = '0;
		den_d = '0;
		greater_d = 1'b0;
		error_d = 1'b0;
		case (mode_q)
			rau_pkg::MODE_ADD: begin
				num_d = e1 + e2;
				den_d = e3;
				error_d = (e3 == '0);
			end
			rau_pkg::MODE_SUB: begin
				num_d = e1 - e2;
				den_d = e3;
				error_d = (e3 == '0);
			end
			rau_pkg::MODE_MUL: begin
				num_d = e4;
				den_d = e3;
				error_d = (e3 == '0);
			end
			rau_pkg::MODE_DIV: begin
				num_d = e1;
				den_d = e2;
				error_d = (e2 == '0);
			end
			rau_pkg::MODE_RED: begin
				if (gx_q == '0) begin
					error_d = 1'b1;
				end else begin
					num_d = eqn;
					den_d = eqd;
					error_d = (eqd == '0);
				end
			end
			rau_pkg::MODE_CMP: begin
				greater_d = (p1_q > p2_q);
			end
			default: begin
				error_d = 1'b1;
			end
		endcase
	end

	assign stat.mode = mode_q;
	assign stat.gx_zero = (gx_q == '0);
	assign stat.gy_zero = (gy_q == '0);
	assign stat.div_done = dv_done;

	assign res_num = num_q;
	assign res_den = den_q;
	assign greater = greater_q;
	assign error = error_q;

endmodule

FILE: sv/rau_ctrl.sv
module rau_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  rau_pkg::dp_stat_t  stat,
	output rau_pkg::dp_cmd_t   cmd
);

	rau_pkg::state_t state_q, state_d;
	logic            out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rau_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.div_sel = rau_pkg::DIV_GCD;
		in_ready = 1'b0;
		case (state_q)
			rau_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = rau_pkg::ST_MUL1;
				end
			end
			rau_pkg::ST_MUL1: begin
				if (stat.mode == rau_pkg::MODE_RED) begin
					cmd.gcd_init = 1'b1;
					state_d = rau_pkg::ST_GCD_CHECK;
				end else begin
					cmd.mul1 = 1'b1;
					state_d = rau_pkg::ST_MUL2;
				end
			end
			rau_pkg::ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d = rau_pkg::ST_FIN;
			end
			rau_pkg::ST_GCD_CHECK: begin
				if (!stat.gy_zero) begin
					cmd.div_start = 1'b1;
					state_d = rau_pkg::ST_GCD_WAIT;
				end else if (stat.gx_zero) begin
					state_d = rau_pkg::ST_FIN;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel = rau_pkg::DIV_NUM;
					state_d = rau_pkg::ST_NUM_WAIT;
				end
			end
			rau_pkg::ST_GCD_WAIT: begin
				if (stat.div_done) begin
					cmd.gcd_step = 1'b1;
					state_d = rau_pkg::ST_GCD_CHECK;
				end
			end
			rau_pkg::ST_NUM_WAIT: begin
				if (stat.div_done) begin
					cmd.store_qn = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_sel = rau_pkg::DIV_DEN;
					state_d = rau_pkg::ST_DEN_WAIT;
				end
			end
			rau_pkg::ST_DEN_WAIT: begin
				if (stat.div_done) begin
					state_d = rau_pkg::ST_FIN;
				end
			end
			rau_pkg::ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.finish = 1'b1;
					state_d = rau_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rau_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

FILE: sv/rational_arithmetic_unit.sv
// Rational arithmetic unit: takes one word of two signed fractions a and b with a mode and
// returns one result word. Add, subtract, multiply and divide form exact cross products without
// reducing; compare reports a_num*b_den > a_den*b_num, which is a > b for same-sign denominators;
// reduce divides a by the gcd of its numerator and denominator, found with truncated remainders,
// so the gcd sign can flip the result signs. Arithmetic modes load the operands, form two cross
// products in ST_MUL1 and two in ST_MUL2, and register the result in ST_FIN. Reduce runs every gcd
// remainder step and both final quotients on one shared bit-serial divider. One word is in work
// at a time; the result sits in an output register so the next word is taken while it waits.
module rational_arithmetic_unit (
	input  logic       clk,
	input  logic       arst_n,
	rau_in_if.sink     operands,
	rau_out_if.source  result
);

	rau_pkg::dp_cmd_t  cmd;
	rau_pkg::dp_stat_t stat;

	rau_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (operands.valid),
		.in_ready  (operands.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rau_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.mode    (operands.mode),
		.a_num   (operands.a_num),
		.a_den   (operands.a_den),
		.b_num   (operands.b_num),
		.b_den   (operands.b_den),
		.cmd     (cmd),
		.stat    (stat),
		.res_num (result.res_num),
		.res_den (result.res_den),
		.greater (result.greater),
		.error   (result.error)
	);

endmodule

FILE: sv/rau_checker.sv
`include "rational_arithmetic_unit_assert.svh"

module rau_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic signed [rau_pkg::RES_W-1:0]  res_num,
	input logic signed [rau_pkg::RES_W-1:0]  res_den,
	input logic                              greater,
	input logic                              error
);

	`RAU_ASSERT_NXT(a_valid_hold, out_valid && !out_ready, out_valid)
	`RAU_ASSERT_NXT(a_word_hold, out_valid && !out_ready, $stable(res_num) && $stable(res_den))
	`RAU_ASSERT_IMP(a_greater_clean, out_valid && greater, !error && res_num == '0 && res_den == '0)
	`RAU_ASSERT_IMP(a_den_nonzero, out_valid && !error && !greater, res_den != '0 || res_num == '0)

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.res_num   (result.res_num),
	.res_den   (result.res_den),
	.greater   (result.greater),
	.error     (result.error)
);
